>>> hw/rtl/cgi_pkg.sv
// Shared types, constants and helpers for the color gradient interpolator.
package cgi_pkg;

	localparam int POSITION_BITS = 16;
	localparam int CHANNEL_BITS  = 8;
	localparam int FRACTION_BITS = 16;

	typedef struct packed {
		logic [POSITION_BITS-1:0] sample_position;
		logic [POSITION_BITS-1:0] start_position;
		logic [POSITION_BITS-1:0] end_position;
		logic [CHANNEL_BITS-1:0]  start_red;
		logic [CHANNEL_BITS-1:0]  start_green;
		logic [CHANNEL_BITS-1:0]  start_blue;
		logic [CHANNEL_BITS-1:0]  end_red;
		logic [CHANNEL_BITS-1:0]  end_green;
		logic [CHANNEL_BITS-1:0]  end_blue;
	} sample_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] out_red;
		logic [CHANNEL_BITS-1:0] out_green;
		logic [CHANNEL_BITS-1:0] out_blue;
	} color_result_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
	} color_t;

	// Sextant pair where the hue of a stop starts: red at 0, green at 2, blue at 4.
	typedef enum logic [1:0] {
		BASE_RED,
		BASE_GREEN,
		BASE_BLUE
	} hue_base_t;

	typedef enum logic [1:0] {
		ARC_MIX,
		ARC_UP,
		ARC_DOWN
	} hue_arc_t;

	typedef enum logic [2:0] {
		SEXT_0,
		SEXT_1,
		SEXT_2,
		SEXT_3,
		SEXT_4,
		SEXT_5
	} sextant_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] value;
		logic [CHANNEL_BITS-1:0] delta;
		logic [CHANNEL_BITS-1:0] mag;
		logic                    neg;
		hue_base_t               base;
		logic                    grey;
	} hsv_prep_t;

	typedef struct packed {
		logic      f_zero;
		logic      f_one;
		logic      use_rgb;
		color_t    start_color;
		color_t    end_color;
		hsv_prep_t prep_a;
		hsv_prep_t prep_b;
	} side_t;

	// Max, min, and the hue numerator pieces of one stop.
	function automatic hsv_prep_t hsv_prep(input logic [CHANNEL_BITS-1:0] r,
		input logic [CHANNEL_BITS-1:0] g, input logic [CHANNEL_BITS-1:0] b);
		hsv_prep_t o;
		logic [CHANNEL_BITS-1:0] mx;
		logic [CHANNEL_BITS-1:0] mn;
		logic [CHANNEL_BITS-1:0] hi;
		logic [CHANNEL_BITS-1:0] lo;
		mx = (r > g) ? r : g;
		mn = (r < g) ? r : g;
		if (b > mx) begin
			mx = b;
		end
		if (b < mn) begin
			mn = b;
		end
		priority if (r >= mx) begin
			o.base = BASE_RED;
			hi = g;
			lo = b;
		end else if (g >= mx) begin
			o.base = BASE_GREEN;
			hi = b;
			lo = r;
		end else begin
			o.base = BASE_BLUE;
			hi = r;
			lo = g;
		end
		o.value = mx;
		o.delta = mx - mn;
		o.neg   = hi < lo;
		o.mag   = (hi < lo) ? lo - hi : hi - lo;
		o.grey  = (r == g) && (g == b);
		return o;
	endfunction

endpackage

>>> hw/rtl/cgi_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
module cgi_div_pipe #(
	parameter int DEN_W = 8,
	parameter int Q_W   = 17
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [DEN_W+Q_W-2:0]     num,
	input  logic [DEN_W-1:0]         den,
	output logic [Q_W-1:0]           quo
);

	localparam int NUM_W = DEN_W + Q_W - 1;

	logic [NUM_W-1:0] rem_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]   quo_s [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_stage
		logic [NUM_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [Q_W-1:0]   quo_in;
		logic [NUM_W-1:0] trial;
		logic             ge;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign den_in = den_s[j-1];
			assign quo_in = quo_s[j-1];
		end

		// Divisor aligned to quotient bit Q_W-1-j.
		assign trial = {den_in, {(Q_W-1){1'b0}}} >> j;
		assign ge    = rem_in >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? rem_in - trial : rem_in;
				den_s[j] <= den_in;
				quo_s[j] <= {quo_in[Q_W-2:0], ge};
			end
		end
	end

	assign quo = quo_s[Q_W-1];

endmodule

>>> hw/rtl/cgi_front.sv
// Input stage, fraction and HSV dividers, and the side data delay line.
module cgi_front #(
	parameter int FRAC_BITS = cgi_pkg::FRACTION_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   req_valid,
	input  cgi_pkg::sample_t       req,
	input  logic                   blend_space,
	output logic                   div_valid,
	output cgi_pkg::side_t         side,
	output logic [FRAC_BITS:0]     quo_f,
	output logic [FRAC_BITS:0]     quo_sa,
	output logic [FRAC_BITS:0]     quo_sb,
	output logic [FRAC_BITS:0]     quo_qa,
	output logic [FRAC_BITS:0]     quo_qb
);

	localparam int P  = cgi_pkg::POSITION_BITS;
	localparam int C  = cgi_pkg::CHANNEL_BITS;
	localparam int QW = FRAC_BITS + 1;

	logic           nneg;
	logic           dneg;
	logic [P-1:0]   an;
	logic [P-1:0]   ad;
	cgi_pkg::side_t side_d;

	logic           valid_s1;
	logic [P-1:0]   an_s1;
	logic [P-1:0]   ad_s1;
	cgi_pkg::side_t side_s1;

	logic [QW-1:0]  dly_valid_s;
	cgi_pkg::side_t dly_side_s [QW];

	always_comb begin
		nneg = req.sample_position < req.start_position;
		dneg = req.end_position < req.start_position;
		an = nneg ? req.start_position - req.sample_position
		          : req.sample_position - req.start_position;
		ad = dneg ? req.start_position - req.end_position
		          : req.end_position - req.start_position;
		side_d.f_zero            = (ad == '0) || (an == '0) || (nneg != dneg);
		side_d.f_one             = an >= ad;
		side_d.start_color.red   = req.start_red;
		side_d.start_color.green = req.start_green;
		side_d.start_color.blue  = req.start_blue;
		side_d.end_color.red     = req.end_red;
		side_d.end_color.green   = req.end_green;
		side_d.end_color.blue    = req.end_blue;
		side_d.prep_a = cgi_pkg::hsv_prep(req.start_red, req.start_green, req.start_blue);
		side_d.prep_b = cgi_pkg::hsv_prep(req.end_red, req.end_green, req.end_blue);
		// A grey stop has no hue: fall back to the RGB blend.
		side_d.use_rgb = !blend_space || side_d.prep_a.grey || side_d.prep_b.grey;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			dly_valid_s <= '0;
		end else if (en) begin
			valid_s1    <= req_valid;
			dly_valid_s <= {dly_valid_s[QW-2:0], valid_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_s1         <= an;
			ad_s1         <= ad;
			side_s1       <= side_d;
			dly_side_s[0] <= side_s1;
			for (int j = 1; j < QW; j++) begin
				dly_side_s[j] <= dly_side_s[j-1];
			end
		end
	end

	cgi_div_pipe #(.DEN_W(P), .Q_W(QW)) u_div_f (
		.clk (clk),
		.en  (en),
		.num ({an_s1, {FRAC_BITS{1'b0}}}),
		.den (ad_s1),
		.quo (quo_f)
	);

	// Saturation: (delta * ONE + max / 2) / max.
	cgi_div_pipe #(.DEN_W(C), .Q_W(QW)) u_div_sa (
		.clk (clk),
		.en  (en),
		.num ({side_s1.prep_a.delta, {FRAC_BITS{1'b0}}}
		      + {{FRAC_BITS{1'b0}}, 1'b0, side_s1.prep_a.value[C-1:1]}),
		.den (side_s1.prep_a.value),
		.quo (quo_sa)
	);

	cgi_div_pipe #(.DEN_W(C), .Q_W(QW)) u_div_sb (
		.clk (clk),
		.en  (en),
		.num ({side_s1.prep_b.delta, {FRAC_BITS{1'b0}}}
		      + {{FRAC_BITS{1'b0}}, 1'b0, side_s1.prep_b.value[C-1:1]}),
		.den (side_s1.prep_b.value),
		.quo (quo_sb)
	);

	// Hue offset inside the sextant pair: (mag * ONE + delta / 2) / delta.
	cgi_div_pipe #(.DEN_W(C), .Q_W(QW)) u_div_qa (
		.clk (clk),
		.en  (en),
		.num ({side_s1.prep_a.mag, {FRAC_BITS{1'b0}}}
		      + {{FRAC_BITS{1'b0}}, 1'b0, side_s1.prep_a.delta[C-1:1]}),
		.den (side_s1.prep_a.delta),
		.quo (quo_qa)
	);

	cgi_div_pipe #(.DEN_W(C), .Q_W(QW)) u_div_qb (
		.clk (clk),
		.en  (en),
		.num ({side_s1.prep_b.mag, {FRAC_BITS{1'b0}}}
		      + {{FRAC_BITS{1'b0}}, 1'b0, side_s1.prep_b.delta[C-1:1]}),
		.den (side_s1.prep_b.delta),
		.quo (quo_qb)
	);

	assign div_valid = dly_valid_s[QW-1];
	assign side      = dly_side_s[QW-1];

endmodule

>>> hw/rtl/cgi_back.sv
// Blend stages: hue arc, RGB and HSV mixing, HSV to RGB, output register.
module cgi_back #(
	parameter int FRAC_BITS = cgi_pkg::FRACTION_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   div_valid,
	input  cgi_pkg::side_t         side,
	input  logic [FRAC_BITS:0]     quo_f,
	input  logic [FRAC_BITS:0]     quo_sa,
	input  logic [FRAC_BITS:0]     quo_sb,
	input  logic [FRAC_BITS:0]     quo_qa,
	input  logic [FRAC_BITS:0]     quo_qb,
	output logic                   color_valid,
	output cgi_pkg::color_result_t color
);

	localparam int F   = FRAC_BITS;
	localparam int FW  = F + 1;
	localparam int HW  = F + 3;
	localparam int C   = cgi_pkg::CHANNEL_BITS;
	localparam int CF  = C + F;
	localparam int PRW = C + FW;
	localparam int SPW = 2 * FW;
	localparam int HPW = HW + FW;
	localparam int VPW = CF + FW;

	localparam logic [FW-1:0] FX_ONE   = FW'(1) << F;
	localparam logic [HW-1:0] HUE_HALF = HW'(3) << F;
	localparam logic [HW-1:0] HUE_FULL = HW'(6) << F;
	localparam logic [F-1:0]  RND_F    = F'(1) << (F - 1);
	localparam logic [2*F-1:0] RND_2F  = (2 * F)'(1) << (2 * F - 1);

	function automatic logic [HW-1:0] stop_hue(input cgi_pkg::hue_base_t base,
		input logic neg, input logic [FW-1:0] q);
		logic [HW:0] bs;
		logic [HW:0] qx;
		logic [HW:0] full;
		logic [HW:0] h;
		full = {1'b0, HUE_FULL};
		qx   = (HW + 1)'(q);
		unique case (base)
			cgi_pkg::BASE_GREEN: bs = (HW + 1)'(2) << F;
			cgi_pkg::BASE_BLUE:  bs = (HW + 1)'(4) << F;
			default:             bs = '0;
		endcase
		if (neg) begin
			h = (qx > bs) ? bs + full - qx : bs - qx;
		end else begin
			h = bs + qx;
		end
		if (h >= full) begin
			h = h - full;
		end
		return h[HW-1:0];
	endfunction

	// Stage 2: fraction and stop hues.
	logic                valid_s2, use_rgb_s2;
	logic [FW-1:0]       f_s2, sa_s2, sb_s2;
	logic [HW-1:0]       ha_s2, hb_s2;
	logic [C-1:0]        va_s2, vb_s2;
	cgi_pkg::color_t     ca_s2, cb_s2;
	logic [FW-1:0]       f_d;

	// Stage 3: products and arc choice.
	logic                valid_s3, use_rgb_s3;
	logic [PRW-1:0]      pra_s3 [3];
	logic [PRW-1:0]      prb_s3 [3];
	logic [SPW-1:0]      psa_s3, psb_s3;
	logic [PRW-1:0]      pva_s3, pvb_s3;
	logic [HPW-1:0]      pha_s3, phb_s3;
	cgi_pkg::hue_arc_t   arc_s3;
	logic [HW-1:0]       dist_s3, ha_s3;
	logic [FW-1:0]       f_s3;
	logic [FW-1:0]       fc2;
	logic [C-1:0]        ca2 [3];
	logic [C-1:0]        cb2 [3];
	cgi_pkg::hue_arc_t   arc_d;
	logic [HW-1:0]       dist_d;

	// Stage 4: rounded mixes.
	logic                valid_s4, use_rgb_s4;
	logic [HW-1:0]       step_s4, hmix_s4, ha_s4;
	logic [C-1:0]        rgb_s4 [3];
	logic [FW-1:0]       s_s4;
	logic [CF-1:0]       vq_s4;
	cgi_pkg::hue_arc_t   arc_s4;

	// Stage 5: final hue, sextant split.
	logic                valid_s5, use_rgb_s5, s_zero_s5;
	cgi_pkg::sextant_t   sext_s5;
	logic [F-1:0]        ff_s5;
	logic [FW-1:0]       s_s5;
	logic [CF-1:0]       vq_s5;
	logic [C-1:0]        vv_s5;
	logic [C-1:0]        rgb_s5 [3];
	logic [HW:0]         hx;
	logic [CF-1:0]       vv_sum;

	// Stage 6: saturation scaled factors.
	logic                valid_s6, use_rgb_s6, s_zero_s6;
	cgi_pkg::sextant_t   sext_s6;
	logic [VPW-1:0]      pp_s6;
	logic [FW-1:0]       sf1_s6, sf2_s6;
	logic [CF-1:0]       vq_s6;
	logic [C-1:0]        vv_s6;
	logic [C-1:0]        rgb_s6 [3];
	logic [SPW-1:0]      sf1_sum, sf2_sum;

	// Stage 7: value scaling.
	logic                valid_s7, use_rgb_s7, s_zero_s7;
	cgi_pkg::sextant_t   sext_s7;
	logic [C-1:0]        p_s7;
	logic [VPW-1:0]      qp_s7, tp_s7;
	logic [C-1:0]        vv_s7;
	logic [C-1:0]        rgb_s7 [3];
	logic [VPW:0]        p_sum;

	// Stage 8: output register.
	logic                   valid_s8;
	cgi_pkg::color_result_t color_s8;
	cgi_pkg::color_result_t color_d;
	logic [VPW:0]           q_sum, t_sum;
	logic [C-1:0]           q8, t8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s2 <= div_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	// ---- stage 2
	always_comb begin
		if (side.f_zero) begin
			f_d = '0;
		end else if (side.f_one) begin
			f_d = FX_ONE;
		end else begin
			f_d = quo_f;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s2       <= f_d;
			ha_s2      <= stop_hue(side.prep_a.base, side.prep_a.neg, quo_qa);
			hb_s2      <= stop_hue(side.prep_b.base, side.prep_b.neg, quo_qb);
			sa_s2      <= quo_sa;
			sb_s2      <= quo_sb;
			va_s2      <= side.prep_a.value;
			vb_s2      <= side.prep_b.value;
			ca_s2      <= side.start_color;
			cb_s2      <= side.end_color;
			use_rgb_s2 <= side.use_rgb;
		end
	end

	// ---- stage 3
	always_comb begin
		fc2    = FX_ONE - f_s2;
		ca2[0] = ca_s2.red;
		ca2[1] = ca_s2.green;
		ca2[2] = ca_s2.blue;
		cb2[0] = cb_s2.red;
		cb2[1] = cb_s2.green;
		cb2[2] = cb_s2.blue;
		// Take the shorter way round the circle when the hues sit more than half apart.
		if (ha_s2 > hb_s2 && ha_s2 > HUE_HALF && hb_s2 < ha_s2 - HUE_HALF) begin
			arc_d  = cgi_pkg::ARC_UP;
			dist_d = hb_s2 + HUE_FULL - ha_s2;
		end else if (hb_s2 > ha_s2 && hb_s2 > HUE_HALF && ha_s2 < hb_s2 - HUE_HALF) begin
			arc_d  = cgi_pkg::ARC_DOWN;
			dist_d = ha_s2 + HUE_FULL - hb_s2;
		end else begin
			arc_d  = cgi_pkg::ARC_MIX;
			dist_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pra_s3[k] <= PRW'(ca2[k]) * PRW'(fc2);
				prb_s3[k] <= PRW'(cb2[k]) * PRW'(f_s2);
			end
			psa_s3     <= SPW'(sa_s2) * SPW'(fc2);
			psb_s3     <= SPW'(sb_s2) * SPW'(f_s2);
			pva_s3     <= PRW'(va_s2) * PRW'(fc2);
			pvb_s3     <= PRW'(vb_s2) * PRW'(f_s2);
			pha_s3     <= HPW'(ha_s2) * HPW'(fc2);
			phb_s3     <= HPW'(hb_s2) * HPW'(f_s2);
			arc_s3     <= arc_d;
			dist_s3    <= dist_d;
			ha_s3      <= ha_s2;
			f_s3       <= f_s2;
			use_rgb_s3 <= use_rgb_s2;
		end
	end

	// ---- stage 4
	always_ff @(posedge clk) begin
		if (en) begin
			step_s4 <= HW'((HPW'(dist_s3) * HPW'(f_s3) + HPW'(RND_F)) >> F);
			for (int k = 0; k < 3; k++) begin
				rgb_s4[k] <= C'(((PRW + 1)'(pra_s3[k]) + (PRW + 1)'(prb_s3[k])
				                + (PRW + 1)'(RND_F)) >> F);
			end
			s_s4       <= FW'(((SPW + 1)'(psa_s3) + (SPW + 1)'(psb_s3)
			                  + (SPW + 1)'(RND_F)) >> F);
			vq_s4      <= CF'(pva_s3 + pvb_s3);
			hmix_s4    <= HW'(((HPW + 1)'(pha_s3) + (HPW + 1)'(phb_s3)
			                  + (HPW + 1)'(RND_F)) >> F);
			arc_s4     <= arc_s3;
			ha_s4      <= ha_s3;
			use_rgb_s4 <= use_rgb_s3;
		end
	end

	// ---- stage 5
	always_comb begin
		unique case (arc_s4)
			cgi_pkg::ARC_UP: begin
				hx = {1'b0, ha_s4} + {1'b0, step_s4};
			end
			cgi_pkg::ARC_DOWN: begin
				hx = (step_s4 > ha_s4) ? {1'b0, ha_s4} + {1'b0, HUE_FULL} - {1'b0, step_s4}
				                       : {1'b0, ha_s4} - {1'b0, step_s4};
			end
			default: begin
				hx = {1'b0, hmix_s4};
			end
		endcase
		if (arc_s4 != cgi_pkg::ARC_MIX && hx >= {1'b0, HUE_FULL}) begin
			hx = hx - {1'b0, HUE_FULL};
		end
		if (hx >= {1'b0, HUE_FULL}) begin
			hx = '0;
		end
		vv_sum = vq_s4 + CF'(RND_F);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sext_s5    <= cgi_pkg::sextant_t'(hx[F+2:F]);
			ff_s5      <= hx[F-1:0];
			s_s5       <= s_s4;
			s_zero_s5  <= s_s4 == '0;
			vq_s5      <= vq_s4;
			vv_s5      <= vv_sum[CF-1:F];
			rgb_s5     <= rgb_s4;
			use_rgb_s5 <= use_rgb_s4;
		end
	end

	// ---- stage 6
	always_comb begin
		sf1_sum = SPW'(s_s5) * SPW'(ff_s5) + SPW'(RND_F);
		sf2_sum = SPW'(s_s5) * SPW'(FX_ONE - {1'b0, ff_s5}) + SPW'(RND_F);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s6      <= VPW'(vq_s5) * VPW'(FX_ONE - s_s5);
			sf1_s6     <= FW'(sf1_sum >> F);
			sf2_s6     <= FW'(sf2_sum >> F);
			vq_s6      <= vq_s5;
			vv_s6      <= vv_s5;
			sext_s6    <= sext_s5;
			s_zero_s6  <= s_zero_s5;
			rgb_s6     <= rgb_s5;
			use_rgb_s6 <= use_rgb_s5;
		end
	end

	// ---- stage 7
	assign p_sum = (VPW + 1)'(pp_s6) + (VPW + 1)'(RND_2F);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s7       <= p_sum[2*F+C-1:2*F];
			qp_s7      <= VPW'(vq_s6) * VPW'(FX_ONE - sf1_s6);
			tp_s7      <= VPW'(vq_s6) * VPW'(FX_ONE - sf2_s6);
			vv_s7      <= vv_s6;
			sext_s7    <= sext_s6;
			s_zero_s7  <= s_zero_s6;
			rgb_s7     <= rgb_s6;
			use_rgb_s7 <= use_rgb_s6;
		end
	end

	// ---- stage 8
	always_comb begin
		q_sum = (VPW + 1)'(qp_s7) + (VPW + 1)'(RND_2F);
		t_sum = (VPW + 1)'(tp_s7) + (VPW + 1)'(RND_2F);
		q8    = q_sum[2*F+C-1:2*F];
		t8    = t_sum[2*F+C-1:2*F];
		priority if (use_rgb_s7) begin
			color_d.out_red   = rgb_s7[0];
			color_d.out_green = rgb_s7[1];
			color_d.out_blue  = rgb_s7[2];
		end else if (s_zero_s7) begin
			color_d.out_red   = vv_s7;
			color_d.out_green = vv_s7;
			color_d.out_blue  = vv_s7;
		end else begin
			unique case (sext_s7)
				cgi_pkg::SEXT_0: color_d = '{out_red: vv_s7, out_green: t8,    out_blue: p_s7};
				cgi_pkg::SEXT_1: color_d = '{out_red: q8,    out_green: vv_s7, out_blue: p_s7};
				cgi_pkg::SEXT_2: color_d = '{out_red: p_s7,  out_green: vv_s7, out_blue: t8};
				cgi_pkg::SEXT_3: color_d = '{out_red: p_s7,  out_green: q8,    out_blue: vv_s7};
				cgi_pkg::SEXT_4: color_d = '{out_red: t8,    out_green: p_s7,  out_blue: vv_s7};
				default:         color_d = '{out_red: vv_s7, out_green: p_s7,  out_blue: q8};
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_s8 <= color_d;
		end
	end

	assign color_valid = valid_s8;
	assign color       = color_s8;

endmodule

>>> hw/rtl/color_gradient_interpolate.sv
// Top level of the color gradient interpolator.
// One request per clock goes in unless the pipeline holds, and one blended color
// comes out per request. The path is one input register, FRAC_BITS + 1 divider
// stages that form the stop fraction and the saturation and hue of both stops
// one quotient bit per stage, then seven blend stages ending in the output
// register. The whole pipeline holds while a result waits on color_stall, so
// sample_stall follows color_valid and color_stall.
// blend_space selects RGB (0) or shortest-arc HSV (1); a grey stop always blends
// in RGB. Write it only while no request is in flight; cfg_ready is always high.
module color_gradient_interpolate #(
	parameter int FRAC_BITS = cgi_pkg::FRACTION_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  cgi_pkg::sample_t       sample,
	output logic                   color_valid,
	input  logic                   color_stall,
	output cgi_pkg::color_result_t color,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data
);

	logic                 en;
	logic                 blend_space_q;
	logic                 div_valid;
	cgi_pkg::side_t       side;
	logic [FRAC_BITS:0]   quo_f, quo_sa, quo_sb, quo_qa, quo_qb;

	// Hold every stage while the output register is full and stalled.
	assign en           = !(color_valid && color_stall);
	assign sample_stall = !en;
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_space_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			blend_space_q <= cfg_data;
		end
	end

	cgi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.req_valid   (sample_valid),
		.req         (sample),
		.blend_space (blend_space_q),
		.div_valid   (div_valid),
		.side        (side),
		.quo_f       (quo_f),
		.quo_sa      (quo_sa),
		.quo_sb      (quo_sb),
		.quo_qa      (quo_qa),
		.quo_qb      (quo_qb)
	);

	cgi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.div_valid   (div_valid),
		.side        (side),
		.quo_f       (quo_f),
		.quo_sa      (quo_sa),
		.quo_sb      (quo_sb),
		.quo_qa      (quo_qa),
		.quo_qb      (quo_qb),
		.color_valid (color_valid),
		.color       (color)
	);

endmodule
